### hw/rtl/pime_pkg.sv
// Shared types and constants for the priority inheritance mutex engine.
// Used by the controller, the top level and the port checker; depends on nothing.
`default_nettype none

package pime_pkg;

  localparam int unsigned DefNumTasks   = 16;
  localparam int unsigned DefNumMutexes = 16;

  localparam int unsigned IdWidth    = 4;
  localparam int unsigned PrioWidth  = 8;
  localparam int unsigned MaxResults = 17;
  localparam int unsigned CntWidth   = $clog2(MaxResults + 1);

  localparam logic [PrioWidth-1:0] PrioReset = 8'hFF;

  typedef enum logic [1:0] {
    MODE_LOCK     = 2'd0,
    MODE_UNLOCK   = 2'd1,
    MODE_REGISTER = 2'd2,
    MODE_UNUSED   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    EV_GRANTED    = 3'd0,
    EV_BLOCKED    = 3'd1,
    EV_RAISED     = 3'd2,
    EV_RESTORED   = 3'd3,
    EV_WOKEN      = 3'd4,
    EV_IDLE       = 3'd5,
    EV_REGISTERED = 3'd6
  } ev_kind_e;

  // One result word as it leaves the controller.
  typedef struct packed {
    ev_kind_e             kind;
    logic [IdWidth-1:0]   ev_task;
    logic [PrioWidth-1:0] prio;
    logic                 sw;
    logic                 last;
  } ev_t;

endpackage

`default_nettype wire

### hw/rtl/pime_ram.sv
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read. No dependencies.
`default_nettype none

module pime_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = 4
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read data holds when no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/pime_ctrl.sv
// Sequencer of the mutex engine: owns the task and mutex tables and walks
// wait lists and inheritance chains. Depends on pime_pkg and pime_ram.
`default_nettype none

module pime_ctrl
  import pime_pkg::*;
#(
  parameter int unsigned NUM_TASKS   = DefNumTasks,
  parameter int unsigned NUM_MUTEXES = DefNumMutexes
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [1:0]           in_mode_i,
  input  wire logic [IdWidth-1:0]   in_task_i,
  input  wire logic [IdWidth-1:0]   in_mutex_i,
  input  wire logic [PrioWidth-1:0] in_prio_i,
  input  wire logic                 out_ready_i,
  output logic                      push_o,
  output ev_t                       push_ev_o
);

  localparam int unsigned TW   = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int unsigned MW   = (NUM_MUTEXES > 1) ? $clog2(NUM_MUTEXES) : 1;
  localparam int unsigned SW   = $clog2(NUM_TASKS + 1);
  localparam int unsigned MaxD = (NUM_TASKS > NUM_MUTEXES) ? NUM_TASKS : NUM_MUTEXES;
  localparam int unsigned CW   = $clog2(MaxD + 1);

  typedef struct packed {
    logic [PrioWidth-1:0] base;
    logic [PrioWidth-1:0] eff;
    logic                 wv;
    logic [MW-1:0]        won;
    logic                 nv;
    logic [TW-1:0]        nxt;
  } task_ent_t;

  typedef struct packed {
    logic          ov;
    logic [TW-1:0] owner;
    logic          hv;
    logic [TW-1:0] head;
  } mtx_ent_t;

  localparam int unsigned TEW = $bits(task_ent_t);
  localparam int unsigned MEW = $bits(mtx_ent_t);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_LOAD, ST_ENQ_HEAD, ST_ENQ_STEP, ST_ENQ_NEXT, ST_INS,
    ST_T_WR, ST_RAISE_RD, ST_RAISE_CHK, ST_RAISE_MX, ST_UNL_RD, ST_UNL_W, ST_FIN
  } state_e;

  state_e               state_q, state_d;
  logic [1:0]           mode_q, mode_d;
  logic [IdWidth-1:0]   t_q, t_d;
  logic [IdWidth-1:0]   m_q, m_d;
  logic [PrioWidth-1:0] bp_q, bp_d;
  logic [PrioWidth-1:0] pr_q, pr_d;
  task_ent_t            treq_q, treq_d;
  task_ent_t            cure_q, cure_d;
  mtx_ent_t             me_q, me_d;
  logic [TW-1:0]        own_q, own_d;
  logic [TW-1:0]        cur_q, cur_d;
  logic [SW-1:0]        steps_q, steps_d;
  logic [CntWidth-1:0]  cnt_q, cnt_d;
  ev_t                  pend_q, pend_d;
  logic                 pend_v_q, pend_v_d;
  logic [CW-1:0]        clr_q, clr_d;

  logic          t_we, t_re, m_we, m_re;
  logic [TW-1:0] t_waddr, t_raddr;
  logic [MW-1:0] m_waddr, m_raddr;
  task_ent_t     t_wdata, t_rdata;
  mtx_ent_t      m_wdata, m_rdata;
  logic [TEW-1:0] t_rdata_raw;
  logic [MEW-1:0] m_rdata_raw;

  logic stall;
  logic emit;
  ev_t  ev;
  logic bad_in;

  assign t_rdata = task_ent_t'(t_rdata_raw);
  assign m_rdata = mtx_ent_t'(m_rdata_raw);

  pime_ram #(.Width(TEW), .Depth(NUM_TASKS), .AddrW(TW)) u_task_ram (
    .clk_i   (clk_i),
    .we_i    (t_we),
    .waddr_i (t_waddr),
    .wdata_i (TEW'(t_wdata)),
    .re_i    (t_re),
    .raddr_i (t_raddr),
    .rdata_o (t_rdata_raw)
  );

  pime_ram #(.Width(MEW), .Depth(NUM_MUTEXES), .AddrW(MW)) u_mtx_ram (
    .clk_i   (clk_i),
    .we_i    (m_we),
    .waddr_i (m_waddr),
    .wdata_i (MEW'(m_wdata)),
    .re_i    (m_re),
    .raddr_i (m_raddr),
    .rdata_o (m_rdata_raw)
  );

  assign stall      = pend_v_q && !out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);
  assign bad_in     = (in_mode_i == MODE_UNUSED) || (32'(in_task_i) >= NUM_TASKS) ||
                      ((in_mode_i != MODE_REGISTER) && (32'(in_mutex_i) >= NUM_MUTEXES));

  always_comb begin
    task_ent_t te;
    mtx_ent_t  mx;
    state_d  = state_q;
    mode_d   = mode_q;
    t_d      = t_q;
    m_d      = m_q;
    bp_d     = bp_q;
    pr_d     = pr_q;
    treq_d   = treq_q;
    cure_d   = cure_q;
    me_d     = me_q;
    own_d    = own_q;
    cur_d    = cur_q;
    steps_d  = steps_q;
    cnt_d    = cnt_q;
    pend_d   = pend_q;
    pend_v_d = pend_v_q;
    clr_d    = clr_q;
    t_we     = 1'b0;
    t_re     = 1'b0;
    m_we     = 1'b0;
    m_re     = 1'b0;
    t_waddr  = TW'(t_q);
    t_raddr  = cur_q;
    m_waddr  = MW'(m_q);
    m_raddr  = MW'(m_q);
    t_wdata  = treq_q;
    m_wdata  = me_q;
    emit     = 1'b0;
    ev       = '{kind: EV_GRANTED, ev_task: t_q, prio: pr_q, sw: 1'b0, last: 1'b0};
    push_o    = 1'b0;
    push_ev_o = pend_q;
    te = t_rdata;
    mx = m_rdata;

    unique case (state_q)
      ST_CLEAR: begin
        t_we    = (32'(clr_q) < NUM_TASKS);
        t_waddr = clr_q[TW-1:0];
        t_wdata = '{base: PrioReset, eff: PrioReset, default: '0};
        m_we    = (32'(clr_q) < NUM_MUTEXES);
        m_waddr = clr_q[MW-1:0];
        m_wdata = '0;
        clr_d   = clr_q + CW'(1);
        if (clr_q == CW'(MaxD - 1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_valid_i) begin
          mode_d = in_mode_i;
          t_d    = in_task_i;
          m_d    = in_mutex_i;
          bp_d   = in_prio_i;
          cnt_d  = '0;
          if (!bad_in) begin
            t_re    = 1'b1;
            t_raddr = TW'(in_task_i);
            m_re    = 1'b1;
            m_raddr = (in_mode_i == MODE_REGISTER) ? '0 : MW'(in_mutex_i);
            state_d = ST_LOAD;
          end
        end
      end

      ST_LOAD: begin
        if (!stall) begin
          treq_d = te;
          pr_d   = te.eff;
          me_d   = mx;
          state_d = ST_FIN;
          unique case (mode_q)
            MODE_REGISTER: begin
              t_we         = 1'b1;
              t_wdata      = te;
              t_wdata.base = bp_q;
              t_wdata.eff  = bp_q;
              emit = 1'b1;
              ev   = '{kind: EV_REGISTERED, ev_task: t_q, prio: bp_q, sw: 1'b0, last: 1'b0};
            end
            MODE_LOCK: begin
              if (te.wv) begin
                emit = 1'b1;
                ev   = '{kind: EV_BLOCKED, ev_task: t_q, prio: te.eff, sw: 1'b1, last: 1'b0};
              end else if (!mx.ov) begin
                m_we          = 1'b1;
                m_wdata       = mx;
                m_wdata.ov    = 1'b1;
                m_wdata.owner = TW'(t_q);
                emit = 1'b1;
                ev   = '{kind: EV_GRANTED, ev_task: t_q, prio: te.eff, sw: 1'b0, last: 1'b0};
              end else begin
                own_d      = mx.owner;
                treq_d.wv  = 1'b1;
                treq_d.won = MW'(m_q);
                if (!mx.hv) begin
                  treq_d.nv    = 1'b0;
                  m_we         = 1'b1;
                  m_wdata      = mx;
                  m_wdata.hv   = 1'b1;
                  m_wdata.head = TW'(t_q);
                  state_d      = ST_T_WR;
                end else begin
                  t_re    = 1'b1;
                  t_raddr = mx.head;
                  cur_d   = mx.head;
                  state_d = ST_ENQ_HEAD;
                end
              end
            end
            MODE_UNLOCK: begin
              pr_d = te.base;
              if (te.eff != te.base) begin
                t_we        = 1'b1;
                t_wdata     = te;
                t_wdata.eff = te.base;
                emit = 1'b1;
                ev   = '{kind: EV_RESTORED, ev_task: t_q, prio: te.base, sw: 1'b0,
                         last: 1'b0};
              end
              state_d = ST_UNL_RD;
            end
            default: state_d = ST_FIN;
          endcase
        end
      end

      ST_ENQ_HEAD: begin
        if (!stall) begin
          if (pr_q < te.eff) begin
            treq_d.nv    = 1'b1;
            treq_d.nxt   = cur_q;
            m_we         = 1'b1;
            m_wdata      = me_q;
            m_wdata.hv   = 1'b1;
            m_wdata.head = TW'(t_q);
            state_d      = ST_T_WR;
          end else begin
            cure_d  = te;
            steps_d = '0;
            state_d = ST_ENQ_STEP;
          end
        end
      end

      ST_ENQ_STEP: begin
        if (!stall) begin
          if (!cure_q.nv || (steps_q == SW'(NUM_TASKS))) begin
            state_d = ST_INS;
          end else begin
            t_re    = 1'b1;
            t_raddr = cure_q.nxt;
            state_d = ST_ENQ_NEXT;
          end
        end
      end

      ST_ENQ_NEXT: begin
        if (!stall) begin
          if (te.eff > pr_q) begin
            state_d = ST_INS;
          end else begin
            cur_d   = cure_q.nxt;
            cure_d  = te;
            steps_d = steps_q + SW'(1);
            state_d = ST_ENQ_STEP;
          end
        end
      end

      ST_INS: begin
        if (!stall) begin
          treq_d.nv   = cure_q.nv;
          treq_d.nxt  = cure_q.nxt;
          t_we        = 1'b1;
          t_waddr     = cur_q;
          t_wdata     = cure_q;
          t_wdata.nv  = 1'b1;
          t_wdata.nxt = TW'(t_q);
          state_d     = ST_T_WR;
        end
      end

      ST_T_WR: begin
        if (!stall) begin
          t_we    = 1'b1;
          t_waddr = TW'(t_q);
          t_wdata = treq_q;
          emit    = 1'b1;
          ev      = '{kind: EV_BLOCKED, ev_task: t_q, prio: pr_q, sw: 1'b1, last: 1'b0};
          cur_d   = own_q;
          steps_d = '0;
          state_d = ST_RAISE_RD;
        end
      end

      ST_RAISE_RD: begin
        if (!stall) begin
          t_re    = 1'b1;
          t_raddr = cur_q;
          state_d = ST_RAISE_CHK;
        end
      end

      ST_RAISE_CHK: begin
        if (!stall) begin
          if (!(pr_q < te.eff)) begin
            state_d = ST_FIN;
          end else begin
            t_we        = 1'b1;
            t_waddr     = cur_q;
            t_wdata     = te;
            t_wdata.eff = pr_q;
            emit = 1'b1;
            ev   = '{kind: EV_RAISED, ev_task: IdWidth'(cur_q), prio: pr_q, sw: 1'b0,
                     last: 1'b0};
            if (!te.wv) begin
              state_d = ST_FIN;
            end else begin
              m_re    = 1'b1;
              m_raddr = te.won;
              state_d = ST_RAISE_MX;
            end
          end
        end
      end

      ST_RAISE_MX: begin
        if (!stall) begin
          if (!mx.ov) begin
            state_d = ST_FIN;
          end else begin
            cur_d   = mx.owner;
            steps_d = steps_q + SW'(1);
            state_d = ((steps_q + SW'(1)) == SW'(NUM_TASKS)) ? ST_FIN : ST_RAISE_RD;
          end
        end
      end

      ST_UNL_RD: begin
        if (!stall) begin
          if (!me_q.hv) begin
            m_we          = 1'b1;
            m_wdata       = me_q;
            m_wdata.ov    = 1'b0;
            m_wdata.owner = '0;
            emit = 1'b1;
            ev   = '{kind: EV_IDLE, ev_task: t_q, prio: pr_q, sw: 1'b0, last: 1'b0};
            state_d = ST_FIN;
          end else begin
            t_re    = 1'b1;
            t_raddr = me_q.head;
            cur_d   = me_q.head;
            state_d = ST_UNL_W;
          end
        end
      end

      ST_UNL_W: begin
        if (!stall) begin
          m_we    = 1'b1;
          m_wdata = '{ov: 1'b0, owner: '0, hv: te.nv, head: te.nxt};
          t_we    = 1'b1;
          t_waddr = cur_q;
          t_wdata = te;
          t_wdata.nv  = 1'b0;
          t_wdata.nxt = '0;
          t_wdata.wv  = 1'b0;
          t_wdata.won = '0;
          emit = 1'b1;
          ev   = '{kind: EV_WOKEN, ev_task: IdWidth'(cur_q), prio: te.eff,
                   sw: (te.eff < pr_q), last: 1'b0};
          state_d = ST_FIN;
        end
      end

      ST_FIN: begin
        if (!pend_v_q) begin
          state_d = ST_IDLE;
        end else if (out_ready_i) begin
          push_o         = 1'b1;
          push_ev_o.last = 1'b1;
          pend_v_d       = 1'b0;
          state_d        = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase

    // A new result displaces the held one, which is then known not to be last.
    if (emit && (cnt_q < CntWidth'(MaxResults))) begin
      push_o   = pend_v_q;
      pend_d   = ev;
      pend_v_d = 1'b1;
      cnt_d    = cnt_q + CntWidth'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      clr_q    <= '0;
      cnt_q    <= '0;
      pend_v_q <= 1'b0;
      steps_q  <= '0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      cnt_q    <= cnt_d;
      pend_v_q <= pend_v_d;
      steps_q  <= steps_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q <= mode_d;
    t_q    <= t_d;
    m_q    <= m_d;
    bp_q   <= bp_d;
    pr_q   <= pr_d;
    treq_q <= treq_d;
    cure_q <= cure_d;
    me_q   <= me_d;
    own_q  <= own_d;
    cur_q  <= cur_d;
    pend_q <= pend_d;
  end

endmodule

`default_nettype wire

### hw/rtl/priority_inheritance_mutex_engine_top.sv
// Top level of the priority inheritance mutex engine: stream ports and the
// output word register. Depends on pime_pkg and pime_ctrl.
`default_nettype none

// Channel   Dir  tuser               tdata (low bit first)               tlast
// s_axis    in   mode[1:0]           task_id[3:0] mutex_id[7:4]          -
//                                    base_priority[15:8]
// m_axis    out  event_kind[2:0]     event_task[3:0] event_priority[11:4] last
//                                    switch_request[12]
//
// After reset the task and mutex tables are cleared in one pass over
// max(NUM_TASKS, NUM_MUTEXES) entries, during which s_axis_tready stays low.
// From acceptance until s_axis_tready rises again, a lock that blocks walks
// the wait list one waiter at a time and then the owner chain one owner at a
// time, as the task table has a single read port; an unlock that wakes a
// waiter reads the waiter's entry before writing it back. Every word is held
// until the next word or the end of the request so that its tlast is known;
// a stalled m_axis pauses the walk until the output register frees up. One
// request is worked on at a time: s_axis_tready is high only when idle.

module priority_inheritance_mutex_engine_top
  import pime_pkg::*;
#(
  parameter int unsigned NUM_TASKS   = DefNumTasks,
  parameter int unsigned NUM_MUTEXES = DefNumMutexes
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // task_id, mutex_id, base_priority
  input  wire logic [1:0]  s_axis_tuser,  // mode
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,  // event_task, event_priority, switch_request
  output logic [2:0]       m_axis_tuser,  // event_kind
  output logic             m_axis_tlast
);

  logic out_valid_q;
  ev_t  out_q;
  logic out_ready;
  logic push;
  ev_t  push_ev;

  // The output register can take a word when empty or draining this cycle.
  assign out_ready = !out_valid_q || m_axis_tready;

  pime_ctrl #(
    .NUM_TASKS   (NUM_TASKS),
    .NUM_MUTEXES (NUM_MUTEXES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_mode_i   (s_axis_tuser),
    .in_task_i   (s_axis_tdata[3:0]),
    .in_mutex_i  (s_axis_tdata[7:4]),
    .in_prio_i   (s_axis_tdata[15:8]),
    .out_ready_i (out_ready),
    .push_o      (push),
    .push_ev_o   (push_ev)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      out_q <= push_ev;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tdata  = {3'b000, out_q.sw, out_q.prio, out_q.ev_task};
  assign m_axis_tlast  = out_q.last;

endmodule

`default_nettype wire

### hw/rtl/pime_checker.sv
// Port-level checker for the mutex engine top level, with its bind.
// Depends on pime_pkg.
`default_nettype none

module pime_checker
  import pime_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata,
  input wire logic [2:0]  m_axis_tuser
);

  // A word that is not taken stays offered.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output word dropped while stalled");

  // Only blocked and woken words may ask for a switch.
  a_sw_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[12] |->
      (m_axis_tuser == EV_BLOCKED) || (m_axis_tuser == EV_WOKEN))
    else $error("switch request on wrong event kind");

  // A blocked requester always asks for a switch.
  a_blk_sw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == EV_BLOCKED) |-> m_axis_tdata[12])
    else $error("blocked word without switch request");

  // Event kind seven is never produced, and padding bits stay zero.
  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser != 3'd7) && (m_axis_tdata[15:13] == 3'b000))
    else $error("bad event kind or padding");

endmodule

bind priority_inheritance_mutex_engine_top pime_checker u_pime_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

### tb/pime_checker.sv
// Checker for the priority inheritance mutex engine: watches both stream
// channels, predicts the result words and compares them. Depends on pime_pkg.
`timescale 1ns / 100ps

module pime_scoreboard
  import pime_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,
  input  wire logic [1:0]  s_axis_tuser,
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [15:0] m_axis_tdata,
  input  wire logic [2:0]  m_axis_tuser,
  input  wire logic        m_axis_tlast,
  output int               fail_count_o,
  output int               pending_o,
  output int               words_seen_o
);

  localparam int NT = 16;

  typedef struct packed {
    logic [2:0] kind;
    logic [3:0] tsk;
    logic [7:0] prio;
    logic       sw;
    logic       last;
  } event_word_t;

  logic [7:0] base_prio[NT];
  logic [7:0] eff_prio[NT];
  logic       blocked_v[NT];
  logic [3:0] wait_mutex[NT];
  logic       next_v[NT];
  logic [3:0] next_w[NT];
  logic       owned_v[NT];
  logic [3:0] owner_of[NT];
  logic       head_v[NT];
  logic [3:0] head_of[NT];

  event_word_t expected_events[$];
  event_word_t step_events[$];

  function automatic void push_event(ev_kind_e k, logic [3:0] t, logic [7:0] p, logic sw);
    event_word_t e;
    if (step_events.size() >= MaxResults) return;
    e.kind = k; e.tsk = t; e.prio = p; e.sw = sw; e.last = 1'b0;
    step_events.push_back(e);
  endfunction

  // Insert behind every waiter of equal or more urgent priority.
  function automatic void insert_waiter(logic [3:0] m, logic [3:0] t);
    logic [7:0] pr;
    logic [3:0] cur;
    pr = eff_prio[t];
    next_v[t] = 1'b0;
    if (!head_v[m] || pr < eff_prio[head_of[m]]) begin
      next_v[t] = head_v[m];
      next_w[t] = head_of[m];
      head_v[m] = 1'b1;
      head_of[m] = t;
      return;
    end
    cur = head_of[m];
    for (int i = 0; i < NT; i++) begin
      if (!next_v[cur] || eff_prio[next_w[cur]] > pr) break;
      cur = next_w[cur];
    end
    next_v[t] = next_v[cur];
    next_w[t] = next_w[cur];
    next_v[cur] = 1'b1;
    next_w[cur] = t;
  endfunction

  function automatic void predict_request(logic [1:0] mode, logic [3:0] t, logic [3:0] m,
                                          logic [7:0] bp);
    logic [3:0] holder, w;
    logic [7:0] pr;
    step_events.delete();
    case (mode)
      MODE_REGISTER: begin
        base_prio[t] = bp;
        eff_prio[t] = bp;
        push_event(EV_REGISTERED, t, bp, 1'b0);
      end
      MODE_LOCK: begin
        if (blocked_v[t]) begin
          push_event(EV_BLOCKED, t, eff_prio[t], 1'b1);
        end else if (!owned_v[m]) begin
          owned_v[m] = 1'b1;
          owner_of[m] = t;
          push_event(EV_GRANTED, t, eff_prio[t], 1'b0);
        end else begin
          holder = owner_of[m];
          blocked_v[t] = 1'b1;
          wait_mutex[t] = m;
          insert_waiter(m, t);
          pr = eff_prio[t];
          push_event(EV_BLOCKED, t, pr, 1'b1);
          // Walk the owner chain, raising each holder that is less urgent.
          for (int i = 0; i < NT; i++) begin
            if (!(pr < eff_prio[holder])) break;
            eff_prio[holder] = pr;
            push_event(EV_RAISED, holder, pr, 1'b0);
            if (!blocked_v[holder]) break;
            if (!owned_v[wait_mutex[holder]]) break;
            holder = owner_of[wait_mutex[holder]];
          end
        end
      end
      MODE_UNLOCK: begin
        if (eff_prio[t] != base_prio[t]) begin
          eff_prio[t] = base_prio[t];
          push_event(EV_RESTORED, t, eff_prio[t], 1'b0);
        end
        owned_v[m] = 1'b0;
        if (head_v[m]) begin
          w = head_of[m];
          head_v[m] = next_v[w];
          head_of[m] = next_w[w];
          next_v[w] = 1'b0;
          blocked_v[w] = 1'b0;
          push_event(EV_WOKEN, w, eff_prio[w], eff_prio[w] < eff_prio[t]);
        end else begin
          push_event(EV_IDLE, t, eff_prio[t], 1'b0);
        end
      end
      default: ;
    endcase
    if (step_events.size() > 0) step_events[step_events.size()-1].last = 1'b1;
    foreach (step_events[i]) expected_events.push_back(step_events[i]);
  endfunction

  event_word_t got, want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NT; i++) begin
        base_prio[i] = PrioReset; eff_prio[i] = PrioReset;
        blocked_v[i] = 0; next_v[i] = 0; owned_v[i] = 0; head_v[i] = 0;
        wait_mutex[i] = 0; next_w[i] = 0; owner_of[i] = 0; head_of[i] = 0;
      end
      expected_events.delete();
      fail_count_o <= 0;
      words_seen_o <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind = m_axis_tuser; got.tsk = m_axis_tdata[3:0];
        got.prio = m_axis_tdata[11:4]; got.sw = m_axis_tdata[12]; got.last = m_axis_tlast;
        words_seen_o <= words_seen_o + 1;
        if (expected_events.size() == 0) begin
          $display("%0t: unexpected word: expected none, got %h", $time, got);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_events.pop_front();
          if (got !== want || m_axis_tdata[15:13] !== 3'b0) begin
            $display("%0t: mismatch: expected kind %0d task %0d prio %0d sw %0d last %0d,",
                     $time, want.kind, want.tsk, want.prio, want.sw, want.last);
            $display("%0t:   actual kind %0d task %0d prio %0d sw %0d last %0d",
                     $time, got.kind, got.tsk, got.prio, got.sw, got.last);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      // The output word is checked before a request accepted at the same edge
      // is predicted, so the older results keep their place in the queue.
      if (s_axis_tvalid && s_axis_tready)
        predict_request(s_axis_tuser, s_axis_tdata[3:0], s_axis_tdata[7:4], s_axis_tdata[15:8]);
    end
  end

  assign pending_o = expected_events.size();

endmodule

### tb/tb_priority_inheritance_mutex_engine_top.sv
// Testbench top for the priority inheritance mutex engine: drives directed
// and random lock, unlock and register requests with random idling on both
// channels. Depends on pime_pkg, pime_scoreboard and the block's RTL.
`timescale 1ns / 100ps

module tb_priority_inheritance_mutex_engine_top;
  import pime_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;  // task_id, mutex_id, base_priority
  logic [1:0]  s_axis_tuser = '0;  // mode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;       // event_task, event_priority, switch_request
  logic [2:0]  m_axis_tuser;       // event_kind
  logic        m_axis_tlast;

  int fail_count, pending, words_seen;
  int requests_sent;
  bit sink_steady;  // when set, the receiver never stalls

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  priority_inheritance_mutex_engine_top dut (.*);

  pime_scoreboard u_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .fail_count_o(fail_count), .pending_o(pending), .words_seen_o(words_seen)
  );

  // Send one request word, after a random gap; the gap is drawn per word.
  task automatic send_request(mode_e mode, int tsk, int mtx, int prio);
    int gap;
    gap = $urandom_range(0, 18);
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) @(negedge clk_i);
    s_axis_tdata  <= {prio[7:0], mtx[3:0], tsk[3:0]};
    s_axis_tuser  <= mode;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    requests_sent++;
  endtask

  // The receiver stalls for a fresh random number of cycles before each word.
  initial begin
    int stall;
    forever begin
      @(negedge clk_i);
      m_axis_tready <= 1'b0;
      stall = sink_steady ? 0 : $urandom_range(0, 18);
      if (!sink_steady && $urandom_range(0, 3) == 0) stall = 0;
      repeat (stall) @(negedge clk_i);
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // Random phase: mostly well-formed lock and unlock on a few tasks and
  // mutexes so that chains and wait lists build up, plus some noise.
  task automatic random_request();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 12)
      send_request(MODE_REGISTER, $urandom_range(0, 15), $urandom_range(0, 15),
                   $urandom_range(0, 255));
    else if (pick < 55)
      send_request(MODE_LOCK, $urandom_range(0, 7), $urandom_range(0, 3), $urandom_range(0, 255));
    else if (pick < 90)
      send_request(MODE_UNLOCK, $urandom_range(0, 7), $urandom_range(0, 3),
                   $urandom_range(0, 255));
    else if (pick < 95)
      send_request(MODE_UNUSED, $urandom_range(0, 15), $urandom_range(0, 15),
                   $urandom_range(0, 255));
    else
      send_request(mode_e'($urandom_range(0, 1)), $urandom_range(0, 15), $urandom_range(0, 15),
                   $urandom_range(0, 255));
  endtask

  initial begin
    requests_sent = 0;
    sink_steady = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: register extremes, a grant, a transitive raise chain,
    // relock by a waiting task, locking one's own mutex, unlock by a
    // non-owner, an idle release, and the unused mode.
    send_request(MODE_REGISTER, 0, 0, 255);
    send_request(MODE_REGISTER, 15, 15, 0);
    send_request(MODE_REGISTER, 1, 0, 200);
    send_request(MODE_REGISTER, 2, 0, 100);
    send_request(MODE_REGISTER, 3, 0, 10);
    send_request(MODE_LOCK, 0, 0, 0);      // task 0 owns mutex 0
    send_request(MODE_LOCK, 1, 1, 0);      // task 1 owns mutex 1
    send_request(MODE_LOCK, 1, 0, 0);      // task 1 blocks on 0, raises 0
    send_request(MODE_LOCK, 2, 1, 0);      // task 2 blocks on 1, raises 1 then 0
    send_request(MODE_LOCK, 3, 1, 0);      // more urgent waiter goes first
    send_request(MODE_LOCK, 2, 5, 0);      // waiting task locks again
    send_request(MODE_LOCK, 15, 15, 0);    // grant of the highest mutex
    send_request(MODE_LOCK, 15, 15, 0);    // owner queues on its own mutex
    send_request(MODE_UNLOCK, 4, 1, 0);    // non-owner unlocks mutex 1
    send_request(MODE_UNLOCK, 0, 0, 0);    // restore, wake task 1
    send_request(MODE_UNLOCK, 15, 15, 0);  // wake the owner itself
    send_request(MODE_UNLOCK, 15, 15, 0);  // released idle
    send_request(MODE_UNUSED, 15, 15, 255);

    // Let everything drain once before the random part.
    while (pending != 0) @(negedge clk_i);

    for (int i = 0; i < 150; i++) begin
      if (i == 75) begin
        sink_steady = 1'b1;
        while (pending != 0) @(negedge clk_i);
      end
      if (i == 110) sink_steady = 1'b0;
      random_request();
    end

    while (pending != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    $display("Sent %0d requests covering grants, blocking, chained raises,", requests_sent);
    $display("wakeups and registration; %0d result words checked.", words_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

endmodule

### files.f
hw/rtl/pime_pkg.sv
hw/rtl/pime_ram.sv
hw/rtl/pime_ctrl.sv
hw/rtl/priority_inheritance_mutex_engine_top.sv
hw/rtl/pime_checker.sv
tb/pime_checker.sv
tb/tb_priority_inheritance_mutex_engine_top.sv
